### src/smp_pkg.sv
// Shared types and constants for the STUN message parser.
// No dependencies; every other file in src imports this package.
package smp_pkg;

  localparam int unsigned HDR_BYTES = 20;
  localparam int unsigned POS_W     = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SHORT      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } smp_status_t;

  // configuration register indexes
  typedef enum logic {
    CFG_WANTED_TYPE = 1'b0,
    CFG_VALUE_CAP   = 1'b1
  } smp_cfg_idx_t;

  localparam logic [15:0] WANTED_TYPE_RST = 16'd32;
  localparam logic [15:0] VALUE_CAP_RST   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_datagram;
  } smp_in_t;

  typedef struct packed {
    logic        value_valid;
    logic [7:0]  value_data;
    logic        done_res;
    smp_status_t status;
    logic [15:0] message_type;
    logic [15:0] body_length;
    logic [31:0] cookie;
    logic [31:0] tid_high;
    logic [63:0] tid_low;
    logic [14:0] attribute_count;
    logic        found;
    logic [15:0] found_length;
  } smp_out_t;

  // header fields in wire order, 20 bytes
  typedef struct packed {
    logic [15:0] message_type;
    logic [15:0] body_length;
    logic [31:0] cookie;
    logic [31:0] tid_high;
    logic [63:0] tid_low;
  } smp_hdr_t;

  // per-item status from the record walker, after this item's update
  typedef struct packed {
    logic        emit;
    logic        short_dgram;
    logic        body_done;
    logic [14:0] count;
    logic        found;
    logic [15:0] found_length;
  } smp_walk_t;

endpackage

### src/smp_hdr.sv
// Header capture for the STUN message parser: 20-byte shift register.
// Depends on smp_pkg.
module smp_hdr
  import smp_pkg::*;
(
  input  logic       clk,
  input  logic       wr,
  input  logic [7:0] byte_value,
  output smp_hdr_t   hdr
);

  logic [HDR_BYTES*8-1:0] hdr_r;
  logic [HDR_BYTES*8-1:0] hdr_nxt;

  // after twenty header bytes the register holds the header in wire order
  always_comb begin
    hdr_nxt = hdr_r;
    if (wr) begin
      hdr_nxt = {hdr_r[HDR_BYTES*8-9:0], byte_value};
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  assign hdr = smp_hdr_t'(hdr_nxt);

endmodule

### src/smp_walk.sv
// Attribute record walker for the STUN message parser: byte position,
// record header capture, record count and match tracking. Depends on smp_pkg.
module smp_walk
  import smp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  smp_in_t     in_item,
  input  logic [15:0] blen,
  input  logic [15:0] wanted_type,
  input  logic [15:0] value_capacity,
  output logic        hdr_wr,
  output smp_walk_t   walk
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] nro_r, nro_nxt;
  logic [15:0]      rlen_r, rlen_nxt;
  logic [15:0]      rtype_r, rtype_nxt;
  logic [14:0]      count_r, count_nxt;
  logic             seen_r, seen_nxt;
  logic [15:0]      mrem_r, mrem_nxt;
  logic             stop_r, stop_nxt;
  logic [15:0]      mlen_r, mlen_nxt;

  logic [POS_W-1:0] bo;
  logic [POS_W-1:0] rel;
  logic [POS_W-1:0] rounded;
  logic [POS_W-1:0] nro_adv;
  logic [15:0]      vl;
  logic             in_body;
  logic             emit;
  logic             parse;

  always_comb begin
    hdr_wr  = (pos_r < POS_W'(HDR_BYTES));
    bo      = pos_r - POS_W'(HDR_BYTES);
    in_body = !hdr_wr && (bo < {1'b0, blen});
    emit    = in_body && (mrem_r != 16'd0) && (bo < nro_r);
    parse   = in_body && !emit && !stop_r && (bo >= nro_r) &&
              ({1'b0, nro_r} + 18'd4 <= {2'b00, blen});
    rel     = bo - nro_r;
    vl      = {rlen_r[15:8], in_item.byte_value};
    // value padded up to a multiple of four
    rounded = ({1'b0, vl} + POS_W'(3)) & ~POS_W'(3);
    nro_adv = nro_r + POS_W'(4) + rounded;

    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
    nro_nxt   = nro_r;
    rlen_nxt  = rlen_r;
    rtype_nxt = rtype_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    mrem_nxt  = mrem_r;
    stop_nxt  = stop_r;
    mlen_nxt  = mlen_r;

    if (emit) begin
      mrem_nxt = mrem_r - 16'd1;
    end else if (parse) begin
      unique case (rel)
        POS_W'(0): rtype_nxt = {in_item.byte_value, 8'h00};
        POS_W'(1): rtype_nxt = {rtype_r[15:8], in_item.byte_value};
        POS_W'(2): rlen_nxt  = {in_item.byte_value, 8'h00};
        POS_W'(3): begin
          rlen_nxt  = vl;
          count_nxt = count_r + 15'd1;
          nro_nxt   = nro_adv;
          if (!seen_r && (rtype_r == wanted_type)) begin
            seen_nxt = 1'b1;
            mlen_nxt = vl;
            mrem_nxt = (vl <= value_capacity) ? vl : 16'd0;
          end
          // record overruns the body: stop walking after it
          if (nro_adv > {1'b0, blen}) begin
            stop_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    walk.emit         = emit;
    walk.short_dgram  = (pos_nxt < POS_W'(HDR_BYTES));
    walk.body_done    = ({1'b0, pos_nxt} >= 18'(HDR_BYTES) + {2'b00, blen});
    walk.count        = count_nxt;
    walk.found        = seen_nxt;
    walk.found_length = seen_nxt ? mlen_nxt : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      nro_r   <= '0;
      rlen_r  <= '0;
      rtype_r <= '0;
      count_r <= '0;
      seen_r  <= 1'b0;
      mrem_r  <= '0;
      stop_r  <= 1'b0;
      mlen_r  <= '0;
    end else if (step) begin
      if (in_item.end_of_datagram) begin
        // clear frame state after the final byte
        pos_r   <= '0;
        nro_r   <= '0;
        rlen_r  <= '0;
        rtype_r <= '0;
        count_r <= '0;
        seen_r  <= 1'b0;
        mrem_r  <= '0;
        stop_r  <= 1'b0;
        mlen_r  <= '0;
      end else begin
        pos_r   <= pos_nxt;
        nro_r   <= nro_nxt;
        rlen_r  <= rlen_nxt;
        rtype_r <= rtype_nxt;
        count_r <= count_nxt;
        seen_r  <= seen_nxt;
        mrem_r  <= mrem_nxt;
        stop_r  <= stop_nxt;
        mlen_r  <= mlen_nxt;
      end
    end
  end

endmodule

### src/stun_message_parser.sv
// STUN message parser: takes a datagram one byte per item and streams the
// value bytes of the first attribute of the configured type, when its length
// fits the value capacity, then a summary (header fields, status, record
// count, match) on the final byte's result. An item enters every cycle
// unless the input stalls; each byte passes an input register, one pass of
// the header capture and record walker, and a result register. Bytes that
// produce no result never wait on the result channel. Configuration writes
// are taken at once. Depends on smp_pkg, smp_hdr and smp_walk.
module stun_message_parser
  import smp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  smp_in_t      in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output smp_out_t     out_data,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  smp_cfg_idx_t cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [15:0] wanted_type_r;
  logic [15:0] value_cap_r;
  logic        in_v_r;
  smp_in_t     in_r;
  logic        out_v_r;
  smp_out_t    out_r;
  smp_out_t    res;
  smp_hdr_t    hdr;
  smp_walk_t   walk;
  logic        hdr_wr;
  logic        produce;
  logic        out_free;
  logic        adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r <= WANTED_TYPE_RST;
      value_cap_r   <= VALUE_CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WANTED_TYPE: wanted_type_r <= cfg_data;
        CFG_VALUE_CAP:   value_cap_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  smp_hdr u_hdr (
    .clk        (clk),
    .wr         (adv && hdr_wr),
    .byte_value (in_r.byte_value),
    .hdr        (hdr)
  );

  smp_walk u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (adv),
    .in_item        (in_r),
    .blen           (hdr.body_length),
    .wanted_type    (wanted_type_r),
    .value_capacity (value_cap_r),
    .hdr_wr         (hdr_wr),
    .walk           (walk)
  );

  assign produce  = walk.emit || in_r.end_of_datagram;
  assign out_free = !out_v_r || !out_stall;
  // advance the held item unless it needs the result slot and that is full
  assign adv      = in_v_r && (!produce || out_free);
  assign in_stall = in_v_r && !adv;

  always_comb begin
    res             = '0;
    res.value_valid = walk.emit;
    res.value_data  = walk.emit ? in_r.byte_value : 8'h00;
    res.status      = ST_OK;
    if (in_r.end_of_datagram) begin
      res.done_res = 1'b1;
      if (walk.short_dgram) begin
        res.status = ST_SHORT;
      end else begin
        res.message_type = hdr.message_type;
        res.body_length  = hdr.body_length;
        res.cookie       = hdr.cookie;
        res.tid_high     = hdr.tid_high;
        res.tid_low      = hdr.tid_low;
        if (walk.body_done) begin
          res.attribute_count = walk.count;
          res.found           = walk.found;
          res.found_length    = walk.found_length;
        end else begin
          res.status = ST_INCOMPLETE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (out_free) begin
        out_v_r <= adv && produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (out_free && adv && produce) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_out_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.value_valid || out_data.done_res))
    else $error("result without value byte or summary");

  a_no_summary_midframe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.done_res) |->
      (out_data.status == ST_OK && out_data.attribute_count == 15'd0 &&
       !out_data.found))
    else $error("summary fields set on a value-only result");

  a_bad_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.done_res && out_data.status != ST_OK) |->
      (out_data.attribute_count == 15'd0 && !out_data.found &&
       out_data.found_length == 16'd0))
    else $error("count or match reported with a failing status");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && in_v_r))
    else $error("input stalled while the result slot is free");

endmodule

### tb/sv/stun_parse_checker.sv
`timescale 1ns / 100ps
// Result checker for the STUN message parser: tracks register writes and
// accepted bytes, predicts each result and compares it with what comes out.
// Depends on smp_pkg.
module stun_parse_checker
  import smp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_stall,
  input  smp_in_t      in_data,
  input  logic         out_valid,
  input  logic         out_stall,
  input  smp_out_t     out_data,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  smp_cfg_idx_t cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           results_seen
);

  logic [15:0]      wanted_type;
  logic [15:0]      value_cap;

  logic [POS_W-1:0] rx_count;
  smp_hdr_t         hdr;
  int unsigned      rec_off;
  logic [15:0]      rec_type;
  logic [15:0]      rec_len;
  logic [14:0]      rec_count;
  logic             match_seen;
  logic [15:0]      match_len;
  logic [15:0]      match_left;
  logic             walk_done;

  smp_out_t         parse_results_q[$];
  int               err_n;
  int               res_n;

  function automatic void restart_datagram();
    rx_count   = '0;
    hdr        = '0;
    rec_off    = 0;
    rec_type   = '0;
    rec_len    = '0;
    rec_count  = '0;
    match_seen = 1'b0;
    match_len  = '0;
    match_left = '0;
    walk_done  = 1'b0;
  endfunction

  // Advance the parse by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input smp_in_t item, output smp_out_t res);
    int unsigned blen;
    int unsigned off;
    int unsigned rel;
    int unsigned rounded;
    logic [15:0] vlen;
    bit          emit;
    res  = '0;
    emit = 1'b0;
    blen = hdr.body_length;
    if (rx_count < HDR_BYTES) begin
      hdr[$bits(smp_hdr_t) - 1 - 8 * rx_count -: 8] = item.byte_value;
    end else begin
      off = rx_count - HDR_BYTES;
      if (off < blen) begin
        if (match_left != 0 && off < rec_off) begin
          emit           = 1'b1;
          res.value_data = item.byte_value;
          match_left--;
        end else if (!walk_done && off >= rec_off && rec_off + 4 <= blen) begin
          rel = off - rec_off;
          // record header: type hi, type lo, length hi, length lo
          case (rel)
            0: rec_type = {item.byte_value, 8'h00};
            1: rec_type[7:0] = item.byte_value;
            2: rec_len = {item.byte_value, 8'h00};
            3: begin
              vlen      = {rec_len[15:8], item.byte_value};
              rounded   = (vlen + 3) & 32'hFFFF_FFFC;
              rec_len   = vlen;
              rec_count = rec_count + 1'b1;
              rec_off   = (rec_off + 4 + rounded) & POS_MAX;
              if (!match_seen && rec_type == wanted_type) begin
                match_seen = 1'b1;
                match_len  = vlen;
                match_left = (vlen <= value_cap) ? vlen : 16'h0000;
              end
              // value runs past the body: stop walking
              if (rec_off > blen) walk_done = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
    if (rx_count != POS_MAX) rx_count++;

    if (!emit && !item.end_of_datagram) return 1'b0;

    res.value_valid = emit;
    if (item.end_of_datagram) begin
      res.done_res = 1'b1;
      if (rx_count < HDR_BYTES) begin
        res.status = ST_SHORT;
      end else begin
        res.message_type = hdr.message_type;
        res.body_length  = hdr.body_length;
        res.cookie       = hdr.cookie;
        res.tid_high     = hdr.tid_high;
        res.tid_low      = hdr.tid_low;
        if (rx_count >= HDR_BYTES + blen) begin
          res.status          = ST_OK;
          res.attribute_count = rec_count;
          res.found           = match_seen;
          res.found_length    = match_seen ? match_len : 16'h0000;
        end else begin
          res.status = ST_INCOMPLETE;
        end
      end
      restart_datagram();
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    if (err_n < 40) $display("%0t: result %0d: %s", $time, res_n, what);
    err_n++;
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    smp_out_t want;
    if (!rst_n) begin
      wanted_type = WANTED_TYPE_RST;
      value_cap   = VALUE_CAP_RST;
      restart_datagram();
      parse_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WANTED_TYPE: wanted_type = cfg_data;
          CFG_VALUE_CAP:   value_cap = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_data, want)) parse_results_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        res_n++;
        if (parse_results_q.size() == 0) begin
          report_mismatch("result arrived with none outstanding");
        end else begin
          want = parse_results_q.pop_front();
          compare_field("value_valid", out_data.value_valid, want.value_valid);
          compare_field("value_data", out_data.value_data, want.value_data);
          compare_field("done_res", out_data.done_res, want.done_res);
          compare_field("status", out_data.status, want.status);
          compare_field("message_type", out_data.message_type, want.message_type);
          compare_field("body_length", out_data.body_length, want.body_length);
          compare_field("cookie", out_data.cookie, want.cookie);
          compare_field("tid_high", out_data.tid_high, want.tid_high);
          compare_field("tid_low", out_data.tid_low, want.tid_low);
          compare_field("attribute_count", out_data.attribute_count, want.attribute_count);
          compare_field("found", out_data.found, want.found);
          compare_field("found_length", out_data.found_length, want.found_length);
        end
      end
    end
    pending      <= parse_results_q.size();
    fail_count   <= err_n;
    results_seen <= res_n;
  end

endmodule

### tb/sv/stun_message_parser_tb.sv
`timescale 1ns / 100ps
// Top of the STUN message parser testbench: builds datagrams, drives bytes and
// register writes with random gaps and stalls, and gives the verdict.
// Depends on smp_pkg, stun_message_parser and stun_parse_checker.
module stun_message_parser_tb;
  import smp_pkg::*;

  localparam int          PHASES           = 8;
  localparam int          PHASE_BYTES      = 120;
  localparam int          WATCHDOG_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES    = 6;
  localparam logic [31:0] STUN_COOKIE      = 32'h2112_A442;

  typedef enum int {
    DG_WELL,
    DG_TRAIL,
    DG_CUT,
    DG_SHORT,
    DG_OVERRUN,
    DG_ODD,
    DG_NOISE
  } dgram_kind_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  smp_in_t      in_data = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  smp_out_t     out_data;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  smp_cfg_idx_t cfg_index = CFG_WANTED_TYPE;
  logic [15:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int results_seen;

  logic [15:0] cur_wanted = WANTED_TYPE_RST;
  logic [15:0] cur_cap = VALUE_CAP_RST;
  logic [7:0]  body_q[$];
  logic [7:0]  frame_q[$];
  smp_in_t     stream_q[$];
  bit          steady;
  int          bytes_sent;
  int          dgrams_sent;
  int          hold_left;
  int          quiet_cycles;

  stun_message_parser DUT (.*);

  stun_parse_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .results_seen
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result-side stall: alternate free runs and stalls, mostly short
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      hold_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 200) : $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b1;
      hold_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("stun_message_parser_tb: errors");
      $finish;
    end
  end

  function automatic logic [15:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return cur_wanted;
    if (r < 50) return cur_wanted ^ (16'h0001 << $urandom_range(0, 15));
    if (r < 60) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom());
  endfunction

  task automatic add_record(logic [15:0] rtype, logic [15:0] vlen, int nbytes);
    body_q.push_back(rtype[15:8]);
    body_q.push_back(rtype[7:0]);
    body_q.push_back(vlen[15:8]);
    body_q.push_back(vlen[7:0]);
    repeat (nbytes) body_q.push_back(8'($urandom()));
  endtask

  // Wrap body_q in a header, shape it by kind and queue it as items.
  task automatic finish_frame(dgram_kind_t kind);
    int          blen;
    int          keep;
    logic [31:0] cookie_w;
    frame_q.delete();
    blen     = body_q.size();
    cookie_w = ($urandom_range(0, 4) != 0) ? STUN_COOKIE : $urandom();
    frame_q.push_back(8'($urandom()));
    frame_q.push_back(8'($urandom()));
    frame_q.push_back(8'(blen >> 8));
    frame_q.push_back(8'(blen));
    for (int i = 3; i >= 0; i--) frame_q.push_back(cookie_w[8 * i +: 8]);
    repeat (12) frame_q.push_back(8'($urandom()));
    foreach (body_q[i]) frame_q.push_back(body_q[i]);
    case (kind)
      DG_TRAIL: repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom()));
      DG_CUT: begin
        keep = $urandom_range(HDR_BYTES, HDR_BYTES + blen - 1);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      DG_SHORT: begin
        keep = $urandom_range(1, HDR_BYTES - 1);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      DG_NOISE: begin
        frame_q.delete();
        repeat ($urandom_range(1, 48)) frame_q.push_back(8'($urandom()));
        // sometimes declare a small body so the noise gets walked
        if (frame_q.size() > 3 && $urandom_range(0, 1) != 0) begin
          frame_q[2] = 8'h00;
          frame_q[3] = 8'($urandom_range(0, 28));
        end
      end
      default: ;
    endcase
    foreach (frame_q[i]) stream_q.push_back('{frame_q[i], i == frame_q.size() - 1});
    steady = ($urandom_range(0, 99) < 15);
  endtask

  task automatic make_datagram(dgram_kind_t kind);
    int r;
    int vlen;
    body_q.delete();
    if (kind != DG_NOISE && kind != DG_SHORT) begin
      repeat ($urandom_range((kind == DG_CUT) ? 1 : 0, 4)) begin
        r = $urandom_range(0, 99);
        if (r < 45) vlen = $urandom_range(0, 8);
        else if (r < 70) vlen = $urandom_range(9, 24);
        else if (r < 90 && cur_cap < 40) vlen = $urandom_range((cur_cap == 0) ? 0 : cur_cap - 1,
                                                                cur_cap + 1);
        else vlen = $urandom_range(25, 64);
        add_record(pick_type(), vlen, (vlen + 3) & 32'hFFFF_FFFC);
      end
      if (kind == DG_OVERRUN) begin
        vlen = $urandom_range(1, 40);
        add_record(pick_type(), vlen, $urandom_range(0, vlen - 1));
      end
      // leave a partial record header at the body end
      if (kind == DG_ODD) repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom()));
    end
    finish_frame(kind);
  endtask

  task automatic send_byte(smp_in_t item);
    int r;
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (item.end_of_datagram) dgrams_sent++;
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  // Hold input low until every result is out and the pipeline has emptied.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] wanted, logic [15:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WANTED_TYPE;
    cfg_data  <= wanted;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_VALUE_CAP;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cur_wanted = wanted;
    cur_cap    = cap;
  endtask

  initial begin
    int          r;
    int          quota;
    logic [15:0] wanted;
    logic [15:0] cap;
    dgram_kind_t kind;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed datagrams under the reset register values
    stream_q.push_back('{8'hFF, 1'b1});
    for (int i = 0; i < HDR_BYTES - 1; i++) stream_q.push_back('{8'h00, i == HDR_BYTES - 2});
    for (int i = 0; i < HDR_BYTES; i++)
      stream_q.push_back('{(i == 2 || i == 3) ? 8'h00 : 8'hFF, i == HDR_BYTES - 1});
    for (int i = 0; i < HDR_BYTES; i++)
      stream_q.push_back('{(i == 2 || i == 3) ? 8'hFF : 8'h00, i == HDR_BYTES - 1});
    drain_stream();
    body_q.delete();
    add_record(cur_wanted, 5, 8);
    add_record(cur_wanted, 3, 4);
    add_record(16'h0001, 0, 0);
    finish_frame(DG_WELL);
    drain_stream();
    body_q.delete();
    add_record(cur_wanted, 12, 6);
    finish_frame(DG_WELL);
    drain_stream();
    body_q.delete();
    add_record(cur_wanted, 8, 8);
    add_record(16'h0007, 4, 4);
    finish_frame(DG_CUT);
    drain_stream();
    for (int k = DG_WELL; k <= DG_NOISE; k++) begin
      make_datagram(dgram_kind_t'(k));
      drain_stream();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        wait_idle();
        case (ph)
          1: begin wanted = 16'h0000; cap = 16'h0000; end
          2: begin wanted = 16'hFFFF; cap = 16'hFFFF; end
          3: begin wanted = 16'h0020; cap = 16'd8; end
          default: begin
            wanted = 16'($urandom());
            cap    = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 24)) : 16'($urandom());
          end
        endcase
        write_config(wanted, cap);
      end
      // a phase may end inside a datagram; the rest goes out after the write
      quota = bytes_sent + PHASE_BYTES;
      while (bytes_sent < quota || (ph == PHASES - 1 && stream_q.size() != 0)) begin
        if (stream_q.size() == 0) begin
          r = $urandom_range(0, 99);
          if (r < 45) kind = DG_WELL;
          else if (r < 58) kind = DG_TRAIL;
          else if (r < 68) kind = DG_CUT;
          else if (r < 75) kind = DG_SHORT;
          else if (r < 85) kind = DG_OVERRUN;
          else if (r < 92) kind = DG_ODD;
          else kind = DG_NOISE;
          make_datagram(kind);
        end
        send_byte(stream_q.pop_front());
      end
    end

    wait_idle();
    $display("run covered %0d datagrams, %0d bytes, under %0d register settings",
             dgrams_sent, bytes_sent, PHASES);
    $display("%0d results compared, incl. short, truncated, overrunning and trailing input",
             results_seen);
    if (fail_count == 0)
      $display("stun_message_parser_tb: clean");
    else
      $display("stun_message_parser_tb: errors");
    $finish;
  end

endmodule
